### hdl/tdfsm_pkg.sv
// Shared types, codes and default sizes of the table-driven state machine engine.
package tdfsm_pkg;

    localparam int DEF_MACHINE_SLOTS    = 8;
    localparam int DEF_STATE_SLOTS      = 16;
    localparam int DEF_TRANSITION_SLOTS = 64;
    localparam int DEF_NAME_BITS        = 8;

    typedef enum logic [2:0] {
        CMD_CREATE    = 3'd0,
        CMD_ADD_STATE = 3'd1,
        CMD_ADD_TRANS = 3'd2,
        CMD_POST      = 3'd3,
        CMD_QUERY     = 3'd4
    } cmd_code_t;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HANDLE = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_NONE       = 2'd3;

    typedef struct packed {
        logic [2:0] command;
        logic [2:0] machine;
        logic [7:0] src_name;
        logic [7:0] event_code;
        logic [7:0] target_name;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] new_handle;
        logic [7:0] current_name;
        logic [3:0] current_slot;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       status_we;
        logic [1:0] status_val;
        logic       create;
        logic       add_state;
        logic       add_trans;
        logic       name_rd;
        logic       name_rd_slot;
        logic       cur_cap;
        logic       tr_first;
        logic       tr_rd;
        logic       tr_next;
        logic       sl_first;
        logic       sl_next;
        logic       take;
        logic       show_cap;
        logic       out_load;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_create;
        logic is_add_state;
        logic is_add_trans;
        logic is_post;
        logic is_query;
        logic handle_ok;
        logic mach_full;
        logic state_full;
        logic trans_full;
        logic event_zero;
        logic trans_left;
        logic trans_match;
        logic slot_left;
        logic slot_match;
    } sts_t;

endpackage

### hdl/tdfsm_ctrl.sv
// Sequencing controller of the table-driven state machine engine.
module tdfsm_ctrl
    import tdfsm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    output logic rsp_valid,
    input  logic rsp_stall,
    input  sts_t sts,
    output ctl_t ctl
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_EXEC     = 11'b00000000010,
        S_CUR_RD   = 11'b00000000100,
        S_CUR_CAP  = 11'b00000001000,
        S_TR_RD    = 11'b00000010000,
        S_TR_CHK   = 11'b00000100000,
        S_SL_RD    = 11'b00001000000,
        S_SL_CHK   = 11'b00010000000,
        S_SHOW_RD  = 11'b00100000000,
        S_SHOW_CAP = 11'b01000000000,
        S_FIN      = 11'b10000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.status_we = 1'b1;
                state_next    = S_SHOW_RD;
                if (sts.is_create)
                begin
                    if (sts.mach_full)
                    begin
                        ctl.status_val = ST_FULL;
                        state_next     = S_FIN;
                    end
                    else
                    begin
                        ctl.create     = 1'b1;
                        ctl.status_val = ST_OK;
                    end
                end
                else if (!(sts.is_add_state || sts.is_add_trans || sts.is_post
                           || sts.is_query))
                begin
                    ctl.status_val = ST_NONE;
                    state_next     = S_FIN;
                end
                else if (!sts.handle_ok)
                begin
                    ctl.status_val = ST_BAD_HANDLE;
                    state_next     = S_FIN;
                end
                else if (sts.is_add_state)
                begin
                    ctl.status_val = sts.state_full ? ST_FULL : ST_OK;
                    ctl.add_state  = !sts.state_full;
                end
                else if (sts.is_add_trans)
                begin
                    ctl.status_val = sts.trans_full ? ST_FULL : ST_OK;
                    ctl.add_trans  = !sts.trans_full;
                end
                else if (sts.is_post)
                begin
                    // Without a matching arc the request ends as not taken.
                    ctl.status_val = ST_NONE;
                    if (!sts.event_zero)
                    begin
                        state_next = S_CUR_RD;
                    end
                end
                else
                begin
                    ctl.status_val = ST_OK;
                end
            end
            S_CUR_RD:
            begin
                ctl.name_rd = 1'b1;
                state_next  = S_CUR_CAP;
            end
            S_CUR_CAP:
            begin
                ctl.cur_cap  = 1'b1;
                ctl.tr_first = 1'b1;
                state_next   = S_TR_RD;
            end
            S_TR_RD:
            begin
                if (sts.trans_left)
                begin
                    ctl.tr_rd  = 1'b1;
                    state_next = S_TR_CHK;
                end
                else
                begin
                    state_next = S_SHOW_RD;
                end
            end
            S_TR_CHK:
            begin
                if (sts.trans_match)
                begin
                    ctl.sl_first = 1'b1;
                    state_next   = S_SL_RD;
                end
                else
                begin
                    ctl.tr_next = 1'b1;
                    state_next  = S_TR_RD;
                end
            end
            S_SL_RD:
            begin
                if (sts.slot_left)
                begin
                    ctl.name_rd      = 1'b1;
                    ctl.name_rd_slot = 1'b1;
                    state_next       = S_SL_CHK;
                end
                else
                begin
                    // The target does not resolve, so the walk moves on.
                    ctl.tr_next = 1'b1;
                    state_next  = S_TR_RD;
                end
            end
            S_SL_CHK:
            begin
                if (sts.slot_match)
                begin
                    ctl.take       = 1'b1;
                    ctl.status_we  = 1'b1;
                    ctl.status_val = ST_OK;
                    state_next     = S_SHOW_RD;
                end
                else
                begin
                    ctl.sl_next = 1'b1;
                    state_next  = S_SL_RD;
                end
            end
            S_SHOW_RD:
            begin
                ctl.name_rd = 1'b1;
                state_next  = S_SHOW_CAP;
            end
            S_SHOW_CAP:
            begin
                ctl.show_cap = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/tdfsm_dp.sv
// Datapath of the table-driven state machine engine: counters, tables and result.
module tdfsm_dp
    import tdfsm_pkg::*;
#(
    parameter int MACHINE_SLOTS    = DEF_MACHINE_SLOTS,
    parameter int STATE_SLOTS      = DEF_STATE_SLOTS,
    parameter int TRANSITION_SLOTS = DEF_TRANSITION_SLOTS,
    parameter int NAME_BITS        = DEF_NAME_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    output rsp_t rsp,
    input  ctl_t ctl,
    output sts_t sts
);

    localparam int MIDX_W  = (MACHINE_SLOTS > 1) ? $clog2(MACHINE_SLOTS) : 1;
    localparam int MCNT_W  = $clog2(MACHINE_SLOTS + 1);
    localparam int HCMP_W  = (MCNT_W > 3) ? MCNT_W : 3;
    localparam int SIDX_W  = $clog2(STATE_SLOTS);
    localparam int SCNT_W  = $clog2(STATE_SLOTS + 1);
    localparam int TIDX_W  = (TRANSITION_SLOTS > 1) ? $clog2(TRANSITION_SLOTS) : 1;
    localparam int TCNT_W  = $clog2(TRANSITION_SLOTS + 1);
    localparam int NADDR_W = MIDX_W + SIDX_W;
    localparam int TADDR_W = MIDX_W + TIDX_W;
    localparam int ARC_W   = 3 * NAME_BITS;

    req_t                 req_reg;
    logic [MIDX_W-1:0]    mi_reg;
    logic [MCNT_W-1:0]    mcount_reg;
    logic [SCNT_W-1:0]    scnt_reg  [MACHINE_SLOTS];
    logic [TCNT_W-1:0]    tcnt_reg  [MACHINE_SLOTS];
    logic [SIDX_W-1:0]    cslot_reg [MACHINE_SLOTS];
    logic [TCNT_W-1:0]    i_reg;
    logic [SCNT_W-1:0]    j_reg;
    logic [NAME_BITS-1:0] cur_name_reg;
    logic [1:0]           status_reg;
    logic [2:0]           handle_reg;
    logic [NAME_BITS-1:0] name_reg;
    logic [SIDX_W-1:0]    slot_reg;
    rsp_t                 rsp_reg;

    logic [NAME_BITS-1:0] name_mem [1 << NADDR_W];
    logic [ARC_W-1:0]     arc_mem  [1 << TADDR_W];
    logic [NAME_BITS-1:0] name_rdata_reg;
    logic [ARC_W-1:0]     arc_rdata_reg;

    logic [NAME_BITS-1:0] sname;
    logic [NAME_BITS-1:0] ev;
    logic [NAME_BITS-1:0] tgt;
    logic [NAME_BITS-1:0] arc_from;
    logic [NAME_BITS-1:0] arc_ev;
    logic [NAME_BITS-1:0] arc_tgt;
    logic [NAME_BITS-1:0] slot_name;
    logic [SIDX_W-1:0]    rd_slot;
    logic [MIDX_W-1:0]    new_idx;

    assign sname   = NAME_BITS'(req_reg.src_name);
    assign ev      = NAME_BITS'(req_reg.event_code);
    assign tgt     = NAME_BITS'(req_reg.target_name);
    assign new_idx = MIDX_W'(mcount_reg);
    assign {arc_from, arc_ev, arc_tgt} = arc_rdata_reg;
    assign rd_slot = ctl.name_rd_slot ? j_reg[SIDX_W-1:0] : cslot_reg[mi_reg];

    // A machine with no states reads name zero in its only slot.
    assign slot_name = (scnt_reg[mi_reg] == '0) ? '0 : name_rdata_reg;

    always_comb
    begin
        sts.is_create    = (req_reg.command == CMD_CREATE);
        sts.is_add_state = (req_reg.command == CMD_ADD_STATE);
        sts.is_add_trans = (req_reg.command == CMD_ADD_TRANS);
        sts.is_post      = (req_reg.command == CMD_POST);
        sts.is_query     = (req_reg.command == CMD_QUERY);
        sts.handle_ok    = (HCMP_W'(req_reg.machine) < HCMP_W'(mcount_reg));
        sts.mach_full    = (mcount_reg == MCNT_W'(MACHINE_SLOTS));
        sts.state_full   = (scnt_reg[mi_reg] == SCNT_W'(STATE_SLOTS));
        sts.trans_full   = (tcnt_reg[mi_reg] == TCNT_W'(TRANSITION_SLOTS));
        sts.event_zero   = (ev == '0);
        sts.trans_left   = (i_reg < tcnt_reg[mi_reg]);
        sts.trans_match  = (arc_from == cur_name_reg) && (arc_ev == ev);
        sts.slot_left    = (j_reg < scnt_reg[mi_reg]);
        sts.slot_match   = (name_rdata_reg == arc_tgt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcount_reg <= '0;
            for (int m = 0; m < MACHINE_SLOTS; m++)
            begin
                scnt_reg[m]  <= '0;
                tcnt_reg[m]  <= '0;
                cslot_reg[m] <= '0;
            end
        end
        else
        begin
            if (ctl.create)
            begin
                mcount_reg         <= mcount_reg + 1'b1;
                scnt_reg[new_idx]  <= '0;
                tcnt_reg[new_idx]  <= '0;
                cslot_reg[new_idx] <= '0;
            end
            if (ctl.add_state)
            begin
                scnt_reg[mi_reg] <= scnt_reg[mi_reg] + 1'b1;
            end
            if (ctl.add_trans)
            begin
                tcnt_reg[mi_reg] <= tcnt_reg[mi_reg] + 1'b1;
            end
            if (ctl.take)
            begin
                cslot_reg[mi_reg] <= j_reg[SIDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg    <= req;
            mi_reg     <= MIDX_W'(req.machine);
            handle_reg <= '0;
            name_reg   <= '0;
            slot_reg   <= '0;
        end
        if (ctl.create)
        begin
            mi_reg     <= new_idx;
            handle_reg <= 3'(mcount_reg);
        end
        if (ctl.status_we)
        begin
            status_reg <= ctl.status_val;
        end
        if (ctl.cur_cap)
        begin
            cur_name_reg <= slot_name;
        end
        if (ctl.tr_first)
        begin
            i_reg <= '0;
        end
        else if (ctl.tr_next)
        begin
            i_reg <= i_reg + 1'b1;
        end
        if (ctl.sl_first)
        begin
            j_reg <= '0;
        end
        else if (ctl.sl_next)
        begin
            j_reg <= j_reg + 1'b1;
        end
        if (ctl.show_cap)
        begin
            name_reg <= slot_name;
            slot_reg <= cslot_reg[mi_reg];
        end
        if (ctl.out_load)
        begin
            rsp_reg.status       <= status_reg;
            rsp_reg.new_handle   <= handle_reg;
            rsp_reg.current_name <= 8'(name_reg);
            rsp_reg.current_slot <= 4'(slot_reg);
        end
    end

    // State name table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.add_state)
        begin
            name_mem[{mi_reg, scnt_reg[mi_reg][SIDX_W-1:0]}] <= sname;
        end
        if (ctl.name_rd)
        begin
            name_rdata_reg <= name_mem[{mi_reg, rd_slot}];
        end
    end

    // Transition table, held as from-name, event and target per entry.
    always_ff @(posedge clk)
    begin
        if (ctl.add_trans)
        begin
            arc_mem[{mi_reg, tcnt_reg[mi_reg][TIDX_W-1:0]}] <= {sname, ev, tgt};
        end
        if (ctl.tr_rd)
        begin
            arc_rdata_reg <= arc_mem[{mi_reg, i_reg[TIDX_W-1:0]}];
        end
    end

    assign rsp = rsp_reg;

endmodule

### hdl/table_driven_state_machine_engine.sv
// A new request is taken only once the response to the last one has been loaded for output.
// Create, add, query and a post of the empty event read the current name before they finish; a bad
// handle, a full machine table or an unknown command finishes at once.
// Other posts first walk the arcs and, for each matching arc, compare its target with the slot names;
// a matching arc whose target names no slot is passed over and the walk goes on.
// Reset (asynchronous, active low) clears the machine count and all per-machine counters.
module table_driven_state_machine_engine
    import tdfsm_pkg::*;
#(
    parameter int MACHINE_SLOTS    = DEF_MACHINE_SLOTS,
    parameter int STATE_SLOTS      = DEF_STATE_SLOTS,
    parameter int TRANSITION_SLOTS = DEF_TRANSITION_SLOTS,
    parameter int NAME_BITS        = DEF_NAME_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    ctl_t ctl;
    sts_t sts;

    tdfsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    tdfsm_dp #(
        .MACHINE_SLOTS    (MACHINE_SLOTS),
        .STATE_SLOTS      (STATE_SLOTS),
        .TRANSITION_SLOTS (TRANSITION_SLOTS),
        .NAME_BITS        (NAME_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .ctl   (ctl),
        .sts   (sts)
    );

endmodule

### sim/tb_table_driven_state_machine_engine.sv
// Self-checking testbench for the table-driven state machine engine, with its own model of the tables.
module tb_table_driven_state_machine_engine;
    import tdfsm_pkg::*;

    localparam int MACHINES      = DEF_MACHINE_SLOTS;
    localparam int STATES        = DEF_STATE_SLOTS;
    localparam int ARCS          = DEF_TRANSITION_SLOTS;
    localparam int NAME_POOL     = 6;
    localparam int EVENT_POOL    = 4;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 1725;
    localparam int QUIET_ITEMS   = 150;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 20000;

    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
    localparam logic [7:0] EMPTY_EVENT      = 8'h00;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Model of the engine's tables.
    int unsigned machine_total;
    int unsigned n_states [MACHINES];
    int unsigned n_arcs [MACHINES];
    int unsigned cur_slot [MACHINES];
    logic [7:0] slot_names [MACHINES][STATES];
    logic [7:0] arc_from [MACHINES][ARCS];
    logic [7:0] arc_event [MACHINES][ARCS];
    logic [7:0] arc_target [MACHINES][ARCS];

    logic [7:0] name_pool [MACHINES][NAME_POOL];
    logic [7:0] event_pool [MACHINES][EVENT_POOL];

    rsp_t awaited_answers[$];
    int unsigned fault_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left = 0;
    bit idle_enabled = 1'b1;

    table_driven_state_machine_engine DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int first_slot_named(input int unsigned m, input logic [7:0] name);
        for (int i = 0; i < n_states[m]; i++)
        begin
            if (slot_names[m][i] == name)
                return i;
        end
        return -1;
    endfunction

    // Applies one request to the model and returns the response it must produce.
    function automatic rsp_t answer_for(input req_t r);
        rsp_t a;
        int unsigned m;
        int slot;
        bit taken;
        logic [7:0] here;
        a = '0;
        m = r.machine;
        taken = 1'b0;
        if (r.command == CMD_CREATE)
        begin
            if (machine_total >= MACHINES)
            begin
                a.status = ST_FULL;
                return a;
            end
            m = machine_total;
            machine_total++;
            n_states[m] = 0;
            n_arcs[m] = 0;
            cur_slot[m] = 0;
            for (int i = 0; i < STATES; i++)
                slot_names[m][i] = '0;
            a.new_handle = 3'(m);
        end
        else if (r.command > CMD_QUERY)
        begin
            a.status = ST_NONE;
            return a;
        end
        else if (m >= machine_total)
        begin
            a.status = ST_BAD_HANDLE;
            return a;
        end
        else if (r.command == CMD_ADD_STATE)
        begin
            if (n_states[m] >= STATES)
                a.status = ST_FULL;
            else
            begin
                slot_names[m][n_states[m]] = r.src_name;
                n_states[m]++;
            end
        end
        else if (r.command == CMD_ADD_TRANS)
        begin
            if (n_arcs[m] >= ARCS)
                a.status = ST_FULL;
            else
            begin
                arc_from[m][n_arcs[m]] = r.src_name;
                arc_event[m][n_arcs[m]] = r.event_code;
                arc_target[m][n_arcs[m]] = r.target_name;
                n_arcs[m]++;
            end
        end
        else if (r.command == CMD_POST)
        begin
            if (r.event_code == EMPTY_EVENT)
                a.status = ST_NONE;
            else
            begin
                here = slot_names[m][cur_slot[m]];
                // An arc whose target names no slot is passed over and the walk goes on.
                for (int i = 0; i < n_arcs[m] && !taken; i++)
                begin
                    if (arc_from[m][i] == here && arc_event[m][i] == r.event_code)
                    begin
                        slot = first_slot_named(m, arc_target[m][i]);
                        if (slot >= 0)
                        begin
                            cur_slot[m] = slot;
                            taken = 1'b1;
                        end
                    end
                end
                if (!taken)
                    a.status = ST_NONE;
            end
        end
        a.current_name = slot_names[m][cur_slot[m]];
        a.current_slot = 4'(cur_slot[m]);
        return a;
    endfunction

    task automatic send_request(input req_t r);
        if (idle_enabled && $urandom_range(0, 2) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        awaited_answers.push_back(answer_for(r));
    endtask

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            fault_count++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_answers
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_answers.size() == 0)
            begin
                fault_count++;
                $error("response with no request outstanding: %h", rsp);
            end
            else
            begin
                want = awaited_answers.pop_front();
                compare_field("status", 8'(want.status), 8'(rsp.status));
                compare_field("new_handle", 8'(want.new_handle), 8'(rsp.new_handle));
                compare_field("current_name", want.current_name, rsp.current_name);
                compare_field("current_slot", 8'(want.current_slot), 8'(rsp.current_slot));
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (idle_enabled && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic test_before_create();
        send_request(req_t'{CMD_QUERY, 3'd0, 8'h00, 8'h00, 8'h00});
        send_request(req_t'{CMD_POST, 3'd7, 8'hFF, 8'hFF, 8'hFF});
        send_request(req_t'{CMD_ADD_STATE, 3'd3, 8'h5A, 8'h00, 8'h00});
        send_request(req_t'{CMD_ADD_TRANS, 3'd5, 8'hFF, 8'hFF, 8'hFF});
        send_request(req_t'{CMD_UNUSED_FIRST, 3'd0, 8'h00, 8'h00, 8'h00});
        send_request(req_t'{CMD_UNUSED_LAST, 3'd7, 8'hFF, 8'hFF, 8'hFF});
    endtask

    // A machine with no states: slot 0 reads as name 0 and no target resolves.
    task automatic test_empty_machine();
        send_request(req_t'{CMD_CREATE, 3'd6, 8'h00, 8'h00, 8'h00});
        send_request(req_t'{CMD_QUERY, 3'd0, 8'h00, 8'h00, 8'h00});
        send_request(req_t'{CMD_ADD_TRANS, 3'd0, 8'h00, 8'h01, 8'h00});
        send_request(req_t'{CMD_POST, 3'd0, 8'h00, 8'h01, 8'h00});
        send_request(req_t'{CMD_QUERY, 3'd1, 8'h00, 8'h00, 8'h00});
    endtask

    task automatic test_transition_walk();
        send_request(req_t'{CMD_CREATE, 3'd0, 8'h00, 8'h00, 8'h00});
        send_request(req_t'{CMD_ADD_STATE, 3'd1, 8'hFF, 8'h00, 8'h00});
        send_request(req_t'{CMD_ADD_STATE, 3'd1, 8'h00, 8'h00, 8'h00});
        send_request(req_t'{CMD_ADD_STATE, 3'd1, 8'hAA, 8'h00, 8'h00});
        send_request(req_t'{CMD_ADD_STATE, 3'd1, 8'h55, 8'h00, 8'h00});
        // A repeated name must resolve to its first slot.
        send_request(req_t'{CMD_ADD_STATE, 3'd1, 8'hAA, 8'h00, 8'h00});
        send_request(req_t'{CMD_ADD_TRANS, 3'd1, 8'hFF, 8'hFF, 8'h11});
        send_request(req_t'{CMD_ADD_TRANS, 3'd1, 8'hFF, 8'hFF, 8'hAA});
        send_request(req_t'{CMD_ADD_TRANS, 3'd1, 8'hAA, 8'h01, 8'h55});
        send_request(req_t'{CMD_POST, 3'd1, 8'h00, EMPTY_EVENT, 8'h00});
        send_request(req_t'{CMD_POST, 3'd1, 8'h00, 8'hFF, 8'h00});
        send_request(req_t'{CMD_POST, 3'd1, 8'h00, 8'h80, 8'h00});
        send_request(req_t'{CMD_POST, 3'd1, 8'h00, 8'h01, 8'h00});
        send_request(req_t'{CMD_QUERY, 3'd1, 8'h00, 8'h00, 8'h00});
    endtask

    // Mostly well-formed traffic: names and events come from a small set per machine so that
    // arcs match often, and the low handles receive most adds so that their tables fill up.
    task automatic test_random_traffic(input int unsigned count);
        req_t r;
        int unsigned pick;
        int unsigned m;
        for (int i = 0; i < MACHINES; i++)
        begin
            for (int j = 0; j < NAME_POOL; j++)
                name_pool[i][j] = 8'($urandom);
            for (int j = 0; j < EVENT_POOL; j++)
                event_pool[i][j] = 8'($urandom_range(1, 255));
        end
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                idle_enabled = ($urandom_range(0, 3) != 0);
            if (n >= count - QUIET_ITEMS)
                idle_enabled = 1'b0;
            if (machine_total == 0)
                m = $urandom_range(0, MACHINES - 1);
            else if ($urandom_range(0, 1) == 0)
                m = $urandom_range(0, (machine_total < 3 ? machine_total : 3) - 1);
            else
                m = $urandom_range(0, machine_total - 1);
            r.machine = 3'(m);
            r.src_name = ($urandom_range(0, 99) < 85) ?
                name_pool[m][$urandom_range(0, NAME_POOL - 1)] : 8'($urandom);
            r.target_name = ($urandom_range(0, 99) < 85) ?
                name_pool[m][$urandom_range(0, NAME_POOL - 1)] : 8'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 6)
                r.event_code = EMPTY_EVENT;
            else if (pick < 12)
                r.event_code = 8'($urandom);
            else
                r.event_code = event_pool[m][$urandom_range(0, EVENT_POOL - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 3)
                r.command = CMD_CREATE;
            else if (pick < 13)
                r.command = CMD_ADD_STATE;
            else if (pick < 40)
                r.command = CMD_ADD_TRANS;
            else if (pick < 80)
                r.command = CMD_POST;
            else if (pick < 91)
                r.command = CMD_QUERY;
            else if (pick < 96)
            begin
                r.command = 3'($urandom_range(CMD_CREATE, CMD_QUERY));
                r.machine = 3'($urandom_range(0, MACHINES - 1));
            end
            else
                r.command = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
            send_request(r);
        end
    endtask

    initial
    begin
        req_valid = 1'b0;
        req = '0;
        machine_total = 0;
        for (int i = 0; i < MACHINES; i++)
        begin
            n_states[i] = 0;
            n_arcs[i] = 0;
            cur_slot[i] = 0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_create();
        test_empty_machine();
        test_transition_walk();
        test_random_traffic(RANDOM_ITEMS);

        req_valid <= 1'b0;
        while (awaited_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
hdl/tdfsm_pkg.sv
hdl/tdfsm_ctrl.sv
hdl/tdfsm_dp.sv
hdl/table_driven_state_machine_engine.sv
sim/tb_table_driven_state_machine_engine.sv
